// ===== rtl/avsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsd_pkg: averaging voltmeter seven-segment display package
// Transaction types, field widths and the segment pattern table shared by
// the datapath, the output stage and the port checker.
// ----------------------------------------------------------------------------
package avsd_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 10;
    localparam int SEG_W    = 7;
    localparam int HELD_W   = 6;
    localparam int MEAN_W   = 10;
    localparam int DIGIT_W  = 4;
    localparam int SCALE_W  = 16;

    // Scaling constants: tenths = (mean * 33 + 511) / 1023
    localparam logic [SCALE_W-1:0] SCALE_ROUND = SCALE_W'(511);

    // Action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Input transaction
    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             digit_select;
    } t_out_item;

    // Averaged sample or passing tick, handed from datapath to display stage
    typedef struct packed {
        logic              valid;
        logic              tick;
        logic              done;
        logic [MEAN_W-1:0] mean;
    } t_mean_item;

    // Segment patterns, bit0 = a .. bit6 = g, hex letters above nine
    localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

endpackage

// ===== rtl/averaging_voltmeter_seven_segment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaging_voltmeter_seven_segment: averaging voltmeter display driver
// Averages converter samples over a burst, scales the mean to tenths of a
// volt and drives one multiplexed seven-segment digit per refresh tick.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while o_in_stall is low: a sample
// (action 0) or a refresh tick (action 1). Each tick yields one result, carried
// through the input register, accumulator, reciprocal multiplier and mean
// correction registers and the combinational display stage into the output
// register. Samples give no result. The output has a skid slot; o_in_stall
// rises only when the output register and the skid slot both hold results,
// and the whole pipe then holds. The display shows 00 until the first burst
// completes; digits alternate tens first.
module averaging_voltmeter_seven_segment #(
    parameter int SAMPLES_PER_BURST = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  avsd_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output avsd_pkg::t_out_item  o_out
);
    import avsd_pkg::*;

    logic        w_en;
    t_mean_item  w_mean;
    logic        w_res_valid;
    t_out_item   w_res;

    assign o_in_stall = !w_en;

    // Accumulate bursts and form the mean
    avsd_accum #(
        .SAMPLES_PER_BURST(SAMPLES_PER_BURST)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_item  (i_in),
        .o_mean  (w_mean)
    );

    // Scale, hold and select a digit
    avsd_display u_display (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_mean      (w_mean),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Register results toward the consumer
    avsd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/avsd_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsd_accum: burst accumulator and mean
// Registers the input transaction, sums samples over one burst and divides
// the burst sum by the burst length through a reciprocal multiply with a
// single correction step. Ticks travel alongside in order.
// ----------------------------------------------------------------------------
module avsd_accum #(
    parameter int SAMPLES_PER_BURST = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  avsd_pkg::t_in_item    i_item,
    output avsd_pkg::t_mean_item  o_mean
);
    import avsd_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_BURST);
    localparam int CNT_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;
    localparam int RSH   = SUM_W + 7;
    localparam longint unsigned RECIP_L = (64'd1 << RSH) / SAMPLES_PER_BURST;
    localparam logic [RSH:0]       RECIP = (RSH + 1)'(RECIP_L);
    localparam logic [CNT_W-1:0]   LAST  = CNT_W'(SAMPLES_PER_BURST - 1);
    localparam logic [SUM_W-1:0]   N_SUM = SUM_W'(SAMPLES_PER_BURST);

    // Input register
    logic               r_s0_valid;
    t_in_item           r_s0;

    // Accumulator state
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_cnt;

    // Stage 1: burst sum
    logic               r_s1_valid;
    logic               r_s1_tick;
    logic               r_s1_done;
    logic [SUM_W-1:0]   r_s1_sum;

    // Stage 2: reciprocal estimate
    logic               r_s2_valid;
    logic               r_s2_tick;
    logic               r_s2_done;
    logic [SUM_W-1:0]   r_s2_sum;
    logic [SUM_W-1:0]   r_s2_qest;

    // Stage 3: corrected mean
    logic               r_s3_valid;
    logic               r_s3_tick;
    logic               r_s3_done;
    logic [MEAN_W-1:0]  r_s3_mean;

    logic [SUM_W-1:0]       w_burst_sum;
    logic                   w_last;
    logic                   w_is_sample;
    logic [SUM_W+RSH:0]     w_prod;
    logic [SUM_W-1:0]       w_qn;
    logic [SUM_W-1:0]       w_rem;
    logic [SUM_W-1:0]       w_mean;

    // Add the incoming sample to the running burst sum
    assign w_is_sample = r_s0_valid && (r_s0.action == ACT_SAMPLE);
    assign w_burst_sum = r_sum + SUM_W'(r_s0.sample);
    assign w_last      = (r_cnt == LAST);

    // Estimate sum / N, low by at most one
    assign w_prod = {{(RSH + 1){1'b0}}, r_s1_sum} * {{SUM_W{1'b0}}, RECIP};

    // Correct the estimate with one compare
    assign w_qn   = r_s2_qest * N_SUM;
    assign w_rem  = r_s2_sum - w_qn;
    assign w_mean = (w_rem >= N_SUM) ? r_s2_qest + SUM_W'(1) : r_s2_qest;

    // Advance valid bits and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (w_is_sample) begin
                if (w_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_burst_sum;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0       <= i_item;
            r_s1_tick  <= (r_s0.action == ACT_TICK);
            r_s1_done  <= w_is_sample && w_last;
            r_s1_sum   <= w_burst_sum;
            r_s2_tick  <= r_s1_tick;
            r_s2_done  <= r_s1_done;
            r_s2_sum   <= r_s1_sum;
            r_s2_qest  <= w_prod[RSH +: SUM_W];
            r_s3_tick  <= r_s2_tick;
            r_s3_done  <= r_s2_done;
            r_s3_mean  <= w_mean[MEAN_W-1:0];
        end
    end

    assign o_mean = '{valid: r_s3_valid, tick: r_s3_tick, done: r_s3_done, mean: r_s3_mean};

endmodule

// ===== rtl/avsd_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsd_display: voltage scaling and digit multiplexing
// Scales a finished burst mean to tenths of a volt and holds it. On a tick,
// splits the held value into tens and units and emits one digit pattern.
// ----------------------------------------------------------------------------
module avsd_display (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  avsd_pkg::t_mean_item  i_mean,
    output logic                  o_res_valid,
    output avsd_pkg::t_out_item   o_res
);
    import avsd_pkg::*;

    logic [HELD_W-1:0]  r_held;
    logic               r_show_tens;

    logic [SCALE_W-1:0] w_x;
    logic [SCALE_W-1:0] w_q;
    logic [DIGIT_W-1:0] w_tens;
    logic [HELD_W-1:0]  w_tens_x10;
    logic [HELD_W-1:0]  w_units_full;
    logic [DIGIT_W-1:0] w_units;
    logic               w_tick;

    // Scale: x = mean * 33 + 511, then x / 1023 as (x + x/1024 + 1) / 1024
    assign w_x = (SCALE_W'(i_mean.mean) << 5) + SCALE_W'(i_mean.mean) + SCALE_ROUND;
    assign w_q = (w_x + (w_x >> 10) + SCALE_W'(1)) >> 10;

    // Split the held value into decimal digits
    always_comb begin
        priority if (r_held >= HELD_W'(60)) w_tens = DIGIT_W'(6);
        else if (r_held >= HELD_W'(50))     w_tens = DIGIT_W'(5);
        else if (r_held >= HELD_W'(40))     w_tens = DIGIT_W'(4);
        else if (r_held >= HELD_W'(30))     w_tens = DIGIT_W'(3);
        else if (r_held >= HELD_W'(20))     w_tens = DIGIT_W'(2);
        else if (r_held >= HELD_W'(10))     w_tens = DIGIT_W'(1);
        else                                w_tens = DIGIT_W'(0);
    end

    assign w_tens_x10   = (HELD_W'(w_tens) << 3) + (HELD_W'(w_tens) << 1);
    assign w_units_full = r_held - w_tens_x10;
    assign w_units      = w_units_full[DIGIT_W-1:0];

    // Hold the scaled value and flip the digit on each tick
    assign w_tick = i_mean.valid && i_mean.tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_show_tens <= 1'b1;
        end else if (i_en) begin
            if (i_mean.valid && !i_mean.tick && i_mean.done) begin
                r_held <= w_q[HELD_W-1:0];
            end
            if (w_tick) begin
                r_show_tens <= !r_show_tens;
            end
        end
    end

    // Drive one digit per tick
    assign o_res_valid        = w_tick;
    assign o_res.digit_select = r_show_tens;
    assign o_res.segments     = r_show_tens ? SEG_TABLE[w_tens] : SEG_TABLE[w_units];

endmodule

// ===== rtl/avsd_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsd_skid: output register with skid slot
// Registers each result and parks one more while the consumer stalls, so
// the datapath stops only when both slots hold a transaction.
// ----------------------------------------------------------------------------
module avsd_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  avsd_pkg::t_out_item  i_res,
    output logic                 o_en,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output avsd_pkg::t_out_item  o_out
);
    import avsd_pkg::*;

    logic        r_out_valid;
    t_out_item   r_out;
    logic        r_skid_valid;
    t_out_item   r_skid;
    logic        w_take;
    logic        w_push;

    assign o_en   = !r_skid_valid;
    assign w_take = r_out_valid && !i_out_stall;
    assign w_push = o_en && i_res_valid;

    // Track slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_take) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/avsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsd_checker: port checker for the voltmeter display driver
// Watches the top-level ports for digit alternation, legal segment patterns
// and consistent stall and output behavior.
// ----------------------------------------------------------------------------
module avsd_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  avsd_pkg::t_out_item  o_out
);
    import avsd_pkg::*;

    logic r_expect_tens;
    logic w_out_take;
    logic w_tens_ok;
    logic w_digit_ok;

    assign w_out_take = o_out_valid && !i_out_stall;

    // Track which digit the next delivered transaction must carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_tens <= 1'b1;
        end else if (w_out_take) begin
            r_expect_tens <= !r_expect_tens;
        end
    end

    // Tens never exceeds three; units are any decimal digit
    assign w_tens_ok = (o_out.segments == SEG_TABLE[0]) || (o_out.segments == SEG_TABLE[1])
                    || (o_out.segments == SEG_TABLE[2]) || (o_out.segments == SEG_TABLE[3]);
    assign w_digit_ok = w_tens_ok
                    || (o_out.segments == SEG_TABLE[4]) || (o_out.segments == SEG_TABLE[5])
                    || (o_out.segments == SEG_TABLE[6]) || (o_out.segments == SEG_TABLE[7])
                    || (o_out.segments == SEG_TABLE[8]) || (o_out.segments == SEG_TABLE[9]);

    a_digit_alternates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |-> (o_out.digit_select == r_expect_tens))
        else $error("digit select out of sequence");

    a_segments_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.digit_select && w_tens_ok)
                        || (!o_out.digit_select && w_digit_ok)))
        else $error("illegal segment pattern for selected digit");

    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result dropped or changed");

endmodule

bind averaging_voltmeter_seven_segment avsd_checker u_avsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
